### rtl/core/lpp_pkg.sv
// shared types, codes and helper functions for the length-prefixed pair parser
// no dependencies
package lpp_pkg;

   // widths
   localparam int MAX_LENGTH_BITS = 64;
   localparam int LEN_W           = 64;

   // magic bytes
   localparam logic [7:0] MAGIC_0 = 8'h42;
   localparam logic [7:0] MAGIC_1 = 8'h44;
   localparam logic [7:0] MAGIC_2 = 8'h50;

   // event codes
   localparam logic [2:0] EV_HEADER    = 3'd0;
   localparam logic [2:0] EV_PAYLOAD   = 3'd1;
   localparam logic [2:0] EV_EMPTY     = 3'd2;
   localparam logic [2:0] EV_BAD_MAGIC = 3'd3;
   localparam logic [2:0] EV_BAD_SIZE  = 3'd4;

   // classified input word, from front to back
   typedef struct packed {
      logic [7:0] byte_in;
      logic       restart;
      logic       is_magic_0;
      logic       is_magic_1;
      logic       is_magic_2;
      logic       name_nib_ok;
      logic [1:0] name_code;
      logic       value_nib_ok;
      logic [1:0] value_code;
   } item_type;

   // result word
   typedef struct packed {
      logic [2:0]       event_res;
      logic             is_value;
      logic [7:0]       data_byte;
      logic             last_in_field;
      logic [LEN_W-1:0] field_length;
      logic [3:0]       name_length_bytes;
      logic [3:0]       value_length_bytes;
   } rsp_type;

   // width code of the highest set bit of a nibble
   function automatic logic [1:0] nibble_code(input logic [3:0] nib);
      logic [1:0] code;
      code = 2'd0;
      if (nib[3]) begin
         code = 2'd3;
      end else if (nib[2]) begin
         code = 2'd2;
      end else if (nib[1]) begin
         code = 2'd1;
      end
      return code;
   endfunction

   // length width accepted under the current policy
   function automatic logic code_allowed(input logic [1:0] code, input logic allow_wide);
      logic [6:0] bits;
      bits = 7'd8 << code;
      return !(code == 2'd3 && !allow_wide) && (32'(bits) <= MAX_LENGTH_BITS);
   endfunction

endpackage

### rtl/core/lpp_front.sv
// front end: accepts raw stream words, classifies them and queues them
// depends on lpp_pkg
module lpp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_byte_in,
   input  logic              req_restart,
   output logic              item_valid,
   output lpp_pkg::item_type item,
   input  logic              item_take
);
   import lpp_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   cls;
   logic       push, pop;

   // classify the incoming byte
   always_comb begin
      cls.byte_in      = req_byte_in;
      cls.restart      = req_restart;
      cls.is_magic_0   = (req_byte_in == MAGIC_0);
      cls.is_magic_1   = (req_byte_in == MAGIC_1);
      cls.is_magic_2   = (req_byte_in == MAGIC_2);
      cls.name_nib_ok  = (req_byte_in[7:4] != 4'd0);
      cls.name_code    = nibble_code(req_byte_in[7:4]);
      cls.value_nib_ok = (req_byte_in[3:0] != 4'd0);
      cls.value_code   = nibble_code(req_byte_in[3:0]);
   end

   // queue control
   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign push       = req_push && !req_full;
   assign pop        = item_take && item_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/core/lpp_back.sv
// back end: parse state machine and result queue
// depends on lpp_pkg
module lpp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              item_valid,
   input  lpp_pkg::item_type item,
   output logic              item_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output lpp_pkg::rsp_type  rsp
);
   import lpp_pkg::*;

   localparam logic [2:0] PH_MAGIC0 = 3'd0;
   localparam logic [2:0] PH_MAGIC1 = 3'd1;
   localparam logic [2:0] PH_MAGIC2 = 3'd2;
   localparam logic [2:0] PH_SIZE   = 3'd3;
   localparam logic [2:0] PH_LEN    = 3'd4;
   localparam logic [2:0] PH_DATA   = 3'd5;
   localparam logic [2:0] PH_ERROR  = 3'd6;

   logic             allow_ff;
   logic [2:0]       phase_ff, phase_in;
   logic [2:0]       idx_ff, idx_in;
   logic [LEN_W-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [1:0]       ncode_ff, ncode_in;
   logic [1:0]       vcode_ff, vcode_in;
   logic             in_value_ff, in_value_in;

   logic [2:0]       cur_phase;
   logic [1:0]       wcode;
   logic [LEN_W-1:0] acc_new;
   logic             emit;
   rsp_type          res;

   rsp_type          oq_ff [2];
   logic             oq_wr_ff, oq_rd_ff;
   logic [1:0]       oq_count_ff, oq_count_in;
   logic             oq_push, oq_pop;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b1;
      end else if (csr_write_enable) begin
         allow_ff <= csr_write_data;
      end
   end

   // work on a word whenever the result queue has room
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign item_take = item_valid && ((oq_count_ff != 2'd2) || oq_pop);

   // parse step
   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      ncode_in    = ncode_ff;
      vcode_in    = vcode_ff;
      in_value_in = in_value_ff;
      emit        = 1'b0;
      res         = '0;
      cur_phase   = item.restart ? PH_MAGIC0 : phase_ff;
      wcode       = in_value_ff ? vcode_ff : ncode_ff;
      acc_new     = acc_ff | (LEN_W'(item.byte_in) << {idx_ff, 3'b000});

      unique case (cur_phase)
         PH_MAGIC0, PH_MAGIC1, PH_MAGIC2: begin
            if ((cur_phase == PH_MAGIC0 && !item.is_magic_0) ||
                (cur_phase == PH_MAGIC1 && !item.is_magic_1) ||
                (cur_phase == PH_MAGIC2 && !item.is_magic_2)) begin
               phase_in      = PH_ERROR;
               emit          = 1'b1;
               res.event_res = EV_BAD_MAGIC;
            end else begin
               phase_in = cur_phase + 3'd1;
            end
         end
         PH_SIZE: begin
            emit = 1'b1;
            if (!item.name_nib_ok || !item.value_nib_ok ||
                !code_allowed(item.name_code, allow_ff) ||
                !code_allowed(item.value_code, allow_ff)) begin
               phase_in      = PH_ERROR;
               res.event_res = EV_BAD_SIZE;
            end else begin
               ncode_in               = item.name_code;
               vcode_in               = item.value_code;
               in_value_in            = 1'b0;
               idx_in                 = 3'd0;
               acc_in                 = '0;
               rem_in                 = '0;
               phase_in               = PH_LEN;
               res.event_res          = EV_HEADER;
               res.name_length_bytes  = 4'd1 << item.name_code;
               res.value_length_bytes = 4'd1 << item.value_code;
            end
         end
         PH_LEN: begin
            acc_in = acc_new;
            if (({1'b0, idx_ff} + 4'd1) < (4'd1 << wcode)) begin
               idx_in = idx_ff + 3'd1;
            end else begin
               idx_in = 3'd0;
               if (acc_new == '0) begin
                  emit              = 1'b1;
                  res.event_res     = EV_EMPTY;
                  res.is_value      = in_value_ff;
                  res.last_in_field = 1'b1;
                  in_value_in       = ~in_value_ff;
                  acc_in            = '0;
                  rem_in            = '0;
               end else begin
                  rem_in   = acc_new;
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            emit             = 1'b1;
            res.event_res    = EV_PAYLOAD;
            res.is_value     = in_value_ff;
            res.data_byte    = item.byte_in;
            res.field_length = acc_ff;
            rem_in           = rem_ff - LEN_W'(1);
            if (rem_ff == LEN_W'(1)) begin
               res.last_in_field = 1'b1;
               in_value_in       = ~in_value_ff;
               idx_in            = 3'd0;
               acc_in            = '0;
               rem_in            = '0;
               phase_in          = PH_LEN;
            end
         end
         default: begin
            // error: ignore until restart
            phase_in = PH_ERROR;
         end
      endcase
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC0;
         idx_ff      <= 3'd0;
         ncode_ff    <= 2'd0;
         vcode_ff    <= 2'd0;
         in_value_ff <= 1'b0;
      end else if (item_take) begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         ncode_ff    <= ncode_in;
         vcode_ff    <= vcode_in;
         in_value_ff <= in_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   // result queue
   assign oq_push   = item_take && emit;
   assign rsp_empty = (oq_count_ff == 2'd0);
   assign rsp       = oq_ff[oq_rd_ff];

   always_comb begin
      oq_count_in = oq_count_ff + 2'(oq_push) - 2'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= 1'b0;
         oq_rd_ff    <= 1'b0;
         oq_count_ff <= 2'd0;
      end else begin
         if (oq_push) begin
            oq_wr_ff <= ~oq_wr_ff;
         end
         if (oq_pop) begin
            oq_rd_ff <= ~oq_rd_ff;
         end
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

endmodule

### rtl/core/length_prefixed_pair_parser.sv
// top level of the length-prefixed name/value parser
// depends on lpp_pkg, lpp_front and lpp_back
//
// usage:
//   req_*  input queue: one stream byte per word, req_restart marks the first
//          magic byte of a new package; a word is taken when req_push is high
//          and req_full is low
//   rsp_*  result queue: header, payload, empty-field and error events; the
//          oldest result sits on the ports while rsp_empty is low and leaves
//          when rsp_pop is high
//   csr_*  allow_wide_lengths register, written whenever csr_write_enable is high
// throughput: one byte per cycle while the result queue has room, set by the single parse step in lpp_back
// path: the front queue registers each byte, the parse step takes it from there
//   and writes its result into the result queue, whose oldest entry drives the
//   result ports
// matching magic bytes and the length bytes of a non-empty field give no result
// stall: when the consumer stops popping, the 2-entry result queue fills, the
//   parser stops taking words and the 2-entry front queue raises req_full
// reset: queues empty, parser expects the first magic byte, allow_wide_lengths = 1
module length_prefixed_pair_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [7:0]                req_byte_in,
   input  logic                      req_restart,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [2:0]                rsp_event_res,
   output logic                      rsp_is_value,
   output logic [7:0]                rsp_data_byte,
   output logic                      rsp_last_in_field,
   output logic [lpp_pkg::LEN_W-1:0] rsp_field_length,
   output logic [3:0]                rsp_name_length_bytes,
   output logic [3:0]                rsp_value_length_bytes,
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data
);
   import lpp_pkg::*;

   logic     item_valid;
   logic     item_take;
   item_type item;
   rsp_type  rsp;

   // front end
   lpp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_byte_in (req_byte_in),
      .req_restart (req_restart),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take)
   );

   // back end
   lpp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp              (rsp)
   );

   // result fields
   assign rsp_event_res          = rsp.event_res;
   assign rsp_is_value           = rsp.is_value;
   assign rsp_data_byte          = rsp.data_byte;
   assign rsp_last_in_field      = rsp.last_in_field;
   assign rsp_field_length       = rsp.field_length;
   assign rsp_name_length_bytes  = rsp.name_length_bytes;
   assign rsp_value_length_bytes = rsp.value_length_bytes;

endmodule

### sim/tb_top.sv
// self-checking testbench for length_prefixed_pair_parser: directed and random byte streams
// go in, every event that comes out is checked against a built-in parse model
// depends on lpp_pkg and the parser rtl
module tb_top;
   import lpp_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_LIMIT   = 40;
   localparam int HOLD_CYCLES   = 80;

   typedef enum logic [2:0] {
      ST_WANT_M0, ST_WANT_M1, ST_WANT_M2, ST_SIZE, ST_LENGTH, ST_PAYLOAD, ST_DEAD
   } scan_state_type;

   // dut ports
   logic             clock = 1'b0;
   logic             reset;
   logic             req_push;
   logic             req_full;
   logic [7:0]       req_byte_in;
   logic             req_restart;
   logic             rsp_empty;
   logic             rsp_pop;
   logic [2:0]       rsp_event_res;
   logic             rsp_is_value;
   logic [7:0]       rsp_data_byte;
   logic             rsp_last_in_field;
   logic [LEN_W-1:0] rsp_field_length;
   logic [3:0]       rsp_name_length_bytes;
   logic [3:0]       rsp_value_length_bytes;
   logic             csr_write_enable;
   logic             csr_write_data;

   // parse model state and its copy of the wide-length policy
   scan_state_type scan_state;
   logic [2:0]  len_pos;
   logic [63:0] len_sum;
   logic [63:0] pay_left;
   logic [1:0]  nm_code;
   logic [1:0]  val_code;
   logic        on_value;
   logic        wide_ok;

   // expected events, oldest first
   rsp_type expected_events [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int error_count;
   int cycle_count;
   int words_sent;
   int useful_words;
   int full_stalls;
   int ev_seen [5];

   length_prefixed_pair_parser u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_byte_in            (req_byte_in),
      .req_restart            (req_restart),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_event_res          (rsp_event_res),
      .rsp_is_value           (rsp_is_value),
      .rsp_data_byte          (rsp_data_byte),
      .rsp_last_in_field      (rsp_last_in_field),
      .rsp_field_length       (rsp_field_length),
      .rsp_name_length_bytes  (rsp_name_length_bytes),
      .rsp_value_length_bytes (rsp_value_length_bytes),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // magic byte at a given position of the package start
   function automatic logic [7:0] magic_at(input int pos);
      case (pos)
         0:       return MAGIC_0;
         1:       return MAGIC_1;
         default: return MAGIC_2;
      endcase
   endfunction

   // width code from the highest set bit of a nibble, zero if no bit is set
   function automatic bit top_bit_code(input logic [3:0] nib, output logic [1:0] code);
      code = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (nib[i]) begin
            code = 2'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit width_ok(input logic [1:0] code);
      if (code == 2'd3 && !wide_ok) return 1'b0;
      return (8 << int'(code)) <= MAX_LENGTH_BITS;
   endfunction

   function automatic void open_field();
      len_pos    = 3'd0;
      len_sum    = 64'd0;
      pay_left   = 64'd0;
      scan_state = ST_LENGTH;
   endfunction

   function automatic void clear_scan();
      scan_state = ST_WANT_M0;
      len_pos    = 3'd0;
      len_sum    = 64'd0;
      pay_left   = 64'd0;
      nm_code    = 2'd0;
      val_code   = 2'd0;
      on_value   = 1'b0;
   endfunction

   // one parse step: returns 1 when the byte produces an event
   function automatic bit parse_byte(input logic [7:0] b, input logic rs, output rsp_type ev);
      logic [7:0] want_b;
      logic [1:0] nc;
      logic [1:0] vc;
      logic [1:0] wc;
      ev = '0;
      if (rs) clear_scan();
      case (scan_state)
         ST_WANT_M0, ST_WANT_M1, ST_WANT_M2: begin
            want_b = (scan_state == ST_WANT_M0) ? MAGIC_0 :
                     (scan_state == ST_WANT_M1) ? MAGIC_1 : MAGIC_2;
            if (b != want_b) begin
               scan_state   = ST_DEAD;
               ev.event_res = EV_BAD_MAGIC;
               return 1'b1;
            end
            scan_state = (scan_state == ST_WANT_M0) ? ST_WANT_M1 :
                         (scan_state == ST_WANT_M1) ? ST_WANT_M2 : ST_SIZE;
            return 1'b0;
         end
         ST_SIZE: begin
            if (!top_bit_code(b[7:4], nc) || !top_bit_code(b[3:0], vc) ||
                !width_ok(nc) || !width_ok(vc)) begin
               scan_state   = ST_DEAD;
               ev.event_res = EV_BAD_SIZE;
               return 1'b1;
            end
            nm_code  = nc;
            val_code = vc;
            on_value = 1'b0;
            open_field();
            ev.event_res          = EV_HEADER;
            ev.name_length_bytes  = 4'd1 << nc;
            ev.value_length_bytes = 4'd1 << vc;
            return 1'b1;
         end
         ST_LENGTH: begin
            wc = on_value ? val_code : nm_code;
            len_sum = len_sum | (64'(b) << (8 * int'(len_pos)));
            if ((int'(len_pos) + 1) < (1 << int'(wc))) begin
               len_pos = len_pos + 3'd1;
               return 1'b0;
            end
            len_pos = 3'd0;
            if (len_sum == 64'd0) begin
               ev.event_res     = EV_EMPTY;
               ev.is_value      = on_value;
               ev.last_in_field = 1'b1;
               on_value = ~on_value;
               open_field();
               return 1'b1;
            end
            pay_left   = len_sum;
            scan_state = ST_PAYLOAD;
            return 1'b0;
         end
         ST_PAYLOAD: begin
            ev.event_res    = EV_PAYLOAD;
            ev.is_value     = on_value;
            ev.data_byte    = b;
            ev.field_length = len_sum;
            pay_left = pay_left - 64'd1;
            if (pay_left == 64'd0) begin
               ev.last_in_field = 1'b1;
               on_value = ~on_value;
               open_field();
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // nibble whose highest set bit gives the wanted width code, lower bits random
   function automatic logic [3:0] nibble_for(input logic [1:0] code);
      logic [3:0] top;
      top = 4'd1 << code;
      return top | (4'($urandom) & (top - 4'd1));
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // compare the word on the result ports with the oldest expected event
   task automatic check_result();
      rsp_type want;
      if (expected_events.size() == 0) begin
         report_mismatch("unexpected event", 64'(rsp_event_res), 64'd0);
         return;
      end
      want = expected_events.pop_front();
      if (rsp_event_res !== want.event_res)
         report_mismatch("event_res", 64'(rsp_event_res), 64'(want.event_res));
      if (rsp_is_value !== want.is_value)
         report_mismatch("is_value", 64'(rsp_is_value), 64'(want.is_value));
      if (rsp_data_byte !== want.data_byte)
         report_mismatch("data_byte", 64'(rsp_data_byte), 64'(want.data_byte));
      if (rsp_last_in_field !== want.last_in_field)
         report_mismatch("last_in_field", 64'(rsp_last_in_field), 64'(want.last_in_field));
      if (rsp_field_length !== want.field_length)
         report_mismatch("field_length", rsp_field_length, want.field_length);
      if (rsp_name_length_bytes !== want.name_length_bytes)
         report_mismatch("name_length_bytes", 64'(rsp_name_length_bytes),
                         64'(want.name_length_bytes));
      if (rsp_value_length_bytes !== want.value_length_bytes)
         report_mismatch("value_length_bytes", 64'(rsp_value_length_bytes),
                         64'(want.value_length_bytes));
      if (want.event_res <= EV_BAD_SIZE) ev_seen[want.event_res]++;
   endtask

   // result side: pops with random stalls, long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else begin
            if (rsp_pop && !rsp_empty) check_result();
            if (hold_request > 0) begin
               hold_left    = hold_request;
               hold_request = 0;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_pop <= 1'b0;
            end else begin
               rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
            end
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL length_prefixed_pair_parser");
      $finish;
   end

   // offer one stream byte, wait until it is taken, then predict its event
   task automatic send_word(input logic [7:0] b, input logic rs);
      rsp_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_byte_in <= b;
      req_restart <= rs;
      @(posedge clock);
      while (req_full) begin
         full_stalls++;
         @(posedge clock);
      end
      words_sent++;
      if (!(scan_state == ST_DEAD && !rs)) useful_words++;
      if (parse_byte(b, rs, want)) expected_events.push_back(want);
   endtask

   // stop offering, let all expected events drain, then let the pipe settle
   task automatic wait_idle();
      int n;
      req_push <= 1'b0;
      n = 0;
      while (expected_events.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_wide_policy(input logic allow);
      wait_idle();
      csr_write_data   <= allow;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      wide_ok = allow;
   endtask

   // first count magic bytes, restart on the first one
   task automatic send_magic_prefix(input int count);
      for (int i = 0; i < count; i++) send_word(magic_at(i), i == 0);
   endtask

   task automatic send_random_bytes(input int count);
      for (int i = 0; i < count; i++) send_word(8'($urandom), 1'b0);
   endtask

   // one random package: mostly well formed, some broken, some plain noise
   task automatic send_random_package();
      int          kind;
      int          pick;
      int          nfields;
      int          width;
      int          pos;
      logic [1:0]  codes [2];
      logic [7:0]  bad;
      logic [7:0]  size_byte;
      logic [63:0] flen;
      kind = $urandom_range(99);
      if (kind < 78) begin
         // well-formed header, then alternating fields of random length
         codes[0] = 2'($urandom_range(wide_ok ? 3 : 2));
         codes[1] = 2'($urandom_range(wide_ok ? 3 : 2));
         send_magic_prefix(3);
         send_word({nibble_for(codes[0]), nibble_for(codes[1])}, 1'b0);
         nfields = $urandom_range(6);
         for (int f = 0; f < nfields; f++) begin
            width = 1 << int'(codes[f % 2]);
            pick  = $urandom_range(99);
            if (pick < 15) begin
               flen = 64'd0;
            end else if (pick < 90) begin
               flen = 64'($urandom_range(6, 1));
            end else if (pick < 95) begin
               flen = 64'($urandom_range(40, 7));
            end else if (width == 1) begin
               flen = 64'($urandom_range(255, 200));
            end else begin
               flen = {$urandom, $urandom};
               if (width < 8) flen = flen & ((64'd1 << (8 * width)) - 64'd1);
               flen[8 * width - 8 +: 8] = 8'($urandom_range(255, 1));
            end
            for (int i = 0; i < width; i++) send_word(flen[8 * i +: 8], 1'b0);
            if (pick >= 95) begin
               // truncated field: a few bytes, then the next package cuts in
               send_random_bytes($urandom_range(4));
               return;
            end
            send_random_bytes(int'(flen));
         end
      end else if (kind < 88) begin
         // wrong magic byte at a random position, then ignored bytes
         pos = $urandom_range(2);
         send_magic_prefix(pos);
         bad = 8'($urandom);
         if (bad == magic_at(pos)) bad = bad ^ 8'h01;
         send_word(bad, pos == 0);
         send_random_bytes($urandom_range(3));
      end else if (kind < 96) begin
         // broken size byte: an empty nibble or a refused wide width
         send_magic_prefix(3);
         pick = $urandom_range(wide_ok ? 1 : 2);
         if (pick == 0) begin
            size_byte = {4'h0, 4'($urandom)};
         end else if (pick == 1) begin
            size_byte = {4'($urandom), 4'h0};
         end else if ($urandom_range(1) == 0) begin
            size_byte = {nibble_for(2'd3), nibble_for(2'($urandom))};
         end else begin
            size_byte = {nibble_for(2'($urandom)), nibble_for(2'd3)};
         end
         send_word(size_byte, 1'b0);
         send_random_bytes($urandom_range(3));
      end else begin
         // raw noise with occasional restarts
         pick = $urandom_range(6, 1);
         for (int i = 0; i < pick; i++) send_word(8'($urandom), $urandom_range(4) == 0);
      end
   endtask

   // header, an empty name, a one-byte value, a one-byte name, an empty value
   task automatic test_fields_and_empty();
      send_magic_prefix(3);
      send_word(8'h12, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
   endtask

   // wrong first magic byte on a restart, then a byte that must be ignored
   task automatic test_bad_magic();
      send_word(8'h41, 1'b1);
      send_word(MAGIC_0, 1'b0);
   endtask

   // size byte with an empty value nibble
   task automatic test_bad_size_byte();
      send_magic_prefix(3);
      send_word(8'hF0, 1'b0);
   endtask

   // eight-byte name length refused while the policy forbids it
   task automatic test_wide_refused();
      write_wide_policy(1'b0);
      send_magic_prefix(3);
      send_word(8'h81, 1'b0);
      write_wide_policy(1'b1);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic allow, input int count);
      int start;
      write_wide_policy(allow);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = useful_words;
      while (useful_words - start < count) send_random_package();
   endtask

   // receiver holds off while a long name field streams in, so both queues fill
   task automatic test_back_pressure();
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = HOLD_CYCLES;
      send_magic_prefix(3);
      send_word(8'h11, 1'b0);
      send_word(8'd24, 1'b0);
      send_random_bytes(24);
      send_word(8'h00, 1'b0);
      wait_idle();
   endtask

   // test sequence
   initial begin
      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_byte_in      <= 8'h00;
      req_restart      <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 0;
      error_count   = 0;
      words_sent    = 0;
      useful_words  = 0;
      full_stalls   = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
      wide_ok = 1'b1;
      clear_scan();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_wide_policy(1'b1);
      send_idle_pct = 31;
      recv_idle_pct = 87;
      test_fields_and_empty();
      test_bad_magic();
      test_bad_size_byte();
      test_wide_refused();
      test_random_traffic(31, 87, 1'b0, 150);
      test_back_pressure();
      test_random_traffic(87, 31, 1'b1, 150);
      test_random_traffic(0, 0, 1'b1, 80);
      test_random_traffic(0, 0, 1'b0, 80);

      wait_idle();
      if (expected_events.size() != 0)
         report_mismatch("events never delivered", 64'(expected_events.size()), 64'd0);
      $display("sent %0d bytes; checked header %0d, payload %0d, empty %0d, bad magic %0d, %s",
               words_sent, ev_seen[EV_HEADER], ev_seen[EV_PAYLOAD], ev_seen[EV_EMPTY],
               ev_seen[EV_BAD_MAGIC], $sformatf("bad size %0d", ev_seen[EV_BAD_SIZE]));
      $display("input stalled %0d cycles; wide lengths run both allowed and refused",
               full_stalls);
      if (error_count == 0) begin
         $display("PASS length_prefixed_pair_parser");
      end else begin
         $display("FAIL length_prefixed_pair_parser");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/lpp_pkg.sv
rtl/core/lpp_front.sv
rtl/core/lpp_back.sv
rtl/core/length_prefixed_pair_parser.sv
sim/tb_top.sv
